[sv/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define C3CA_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on the edge that follows a cycle spent in reset.
`define C3CA_ASSERT_RST(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);

`endif

[sv/c3ca_pkg.sv]
package c3ca_pkg;

    localparam int PIX_W       = 8;
    localparam int FRAC_W      = 4;
    localparam int KERN_W      = 3 * PIX_W;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HGT_W   = 13;
    localparam int CFG_DATA_W  = KERN_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int PROD_W      = 2 * PIX_W + 1;
    localparam int RSUM_W      = PROD_W + 2;
    localparam int TOT_W       = RSUM_W + 2;

    localparam int MIN_DIM  = 3;
    localparam int WIN_EDGE = 2;
    localparam int PIX_MAX  = 255;

    localparam logic [CFG_WIDTH_W-1:0] RST_WIDTH  = CFG_WIDTH_W'(1024);
    localparam logic [CFG_HGT_W-1:0]   RST_HEIGHT = CFG_HGT_W'(1024);
    localparam logic [KERN_W-1:0]      RST_K_TOP  = '0;
    localparam logic [KERN_W-1:0]      RST_K_MID  = KERN_W'(24'h001000);
    localparam logic [KERN_W-1:0]      RST_K_BOT  = '0;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [KERN_W-1:0]        kern_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RSUM_W-1:0] rsum_t;
    typedef logic signed [TOT_W-1:0]  tot_t;

    localparam tot_t CONV_SAT = TOT_W'(PIX_MAX * (1 << FRAC_W));

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_K_TOP  = 3'd2,
        CFG_K_MID  = 3'd3,
        CFG_K_BOT  = 3'd4
    } cfg_idx_t;

    // Per-word side information carried down the pipeline.
    typedef struct packed {
        logic produce;
        logic last;
        pix_t acc;
    } tag_t;

    function automatic logic [PIX_W-1:0] kbyte(input kern_t k, input int idx);
        return k[PIX_W*idx +: PIX_W];
    endfunction

    // Signed Q4.4 coefficient times unsigned pixel, exact.
    function automatic prod_t coef_mul(input logic [PIX_W-1:0] c, input pix_t p);
        logic signed [PIX_W:0] pe;
        pe = $signed({1'b0, p});
        return PROD_W'($signed(c) * pe);
    endfunction

endpackage

[sv/conv3x3_clamp_accumulate_unit.sv]
// Channel | Direction | Fields (low bit up)            | Handshake
// s_      | in        | tdata: pixel[7:0], acc_in[15:8] | s_tvalid / s_tready
// m_      | out       | tdata: out_pixel[7:0]; tlast    | m_tvalid / m_tready
// cfg_    | in        | cfg_addr, cfg_wdata             | cfg_we, no wait
// One word per clock while m_tready is high; a result passes stages b, c, d and m.
// The line store is read as a word is taken and written back as it leaves stage b.
// Border words give no result and leave the pipeline after the window stage.
// Reset is synchronous on aresetn low; line stores are not cleared.
// A stalled m_ side fills the pipeline stage by stage before s_tready drops.
`include "assert_macros.svh"

module conv3x3_clamp_accumulate_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // pixel[7:0], acc_in[15:8]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // out_pixel[7:0]
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [c3ca_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [c3ca_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import c3ca_pkg::*;

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WEW = (CFG_WIDTH_W > CW + 1) ? CFG_WIDTH_W : CW + 1;
    localparam int HEW = (CFG_HGT_W > RW + 1) ? CFG_HGT_W : RW + 1;

    // configuration
    logic [CFG_WIDTH_W-1:0] width_reg;
    logic [CFG_HGT_W-1:0]   height_reg;
    kern_t                  k_top_reg;
    kern_t                  k_mid_reg;
    kern_t                  k_bot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            k_top_reg  <= RST_K_TOP;
            k_mid_reg  <= RST_K_MID;
            k_bot_reg  <= RST_K_BOT;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_WIDTH:  width_reg  <= cfg_wdata[CFG_WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[CFG_HGT_W-1:0];
                CFG_K_TOP:  k_top_reg  <= cfg_wdata[KERN_W-1:0];
                CFG_K_MID:  k_mid_reg  <= cfg_wdata[KERN_W-1:0];
                CFG_K_BOT:  k_bot_reg  <= cfg_wdata[KERN_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [WEW-1:0] w_cfg, w_eff, col_inc;
    logic [HEW-1:0] h_cfg, h_eff, row_inc;
    logic           eor, eof, produce;

    // pipeline control
    logic           s_acc, b_adv, c_adv, d_adv;
    logic           b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;
    logic [CW-1:0]  b_col_reg;
    pix_t           b_pix_reg;
    tag_t           b_tag_reg, c_tag_reg;

    always_comb begin
        w_cfg = WEW'(width_reg);
        if (w_cfg < WEW'(MIN_DIM)) begin
            w_eff = WEW'(MIN_DIM);
        end else if (w_cfg > WEW'(MAX_WIDTH)) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        h_cfg = HEW'(height_reg);
        if (h_cfg < HEW'(MIN_DIM)) begin
            h_eff = HEW'(MIN_DIM);
        end else if (h_cfg > HEW'(MAX_HEIGHT)) begin
            h_eff = HEW'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg;
        end
        col_inc = WEW'(col_reg) + WEW'(1);
        row_inc = HEW'(row_reg) + HEW'(1);
        eor     = col_inc >= w_eff;
        eof     = eor && (row_inc >= h_eff);
        produce = (row_reg >= RW'(WIN_EDGE)) && (col_reg >= CW'(WIN_EDGE));
        if (eor) begin
            col_next = '0;
            row_next = eof ? '0 : row_inc[RW-1:0];
        end else begin
            col_next = col_inc[CW-1:0];
            row_next = row_reg;
        end
    end

    assign d_adv    = d_valid_reg && (!m_valid_reg || m_tready);
    assign c_adv    = c_valid_reg && (!d_valid_reg || d_adv);
    assign b_adv    = b_valid_reg && (!c_valid_reg || c_adv);
    assign s_tready = !b_valid_reg || b_adv;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_acc) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            // drop border words here: they only update the line stores and window
            if (b_adv) begin
                c_valid_reg <= b_tag_reg.produce;
            end else if (c_adv) begin
                c_valid_reg <= 1'b0;
            end
            if (c_adv) begin
                d_valid_reg <= 1'b1;
            end else if (d_adv) begin
                d_valid_reg <= 1'b0;
            end
            if (d_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_col_reg         <= col_reg;
            b_pix_reg         <= s_tdata[PIX_W-1:0];
            b_tag_reg.produce <= produce;
            b_tag_reg.last    <= eof;
            b_tag_reg.acc     <= s_tdata[2*PIX_W-1:PIX_W];
        end
        if (b_adv) begin
            c_tag_reg <= b_tag_reg;
        end
    end

    pix_t        top, mid;
    prod_t [8:0] prod;
    pix_t        out_pixel;
    logic        out_last;

    // Same column comes back at least three words later, so the write-back
    // always lands before the next read of that entry.
    c3ca_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .wr_en   (b_adv),
        .wr_addr (b_col_reg),
        .wr_pix  (b_pix_reg),
        .top     (top),
        .mid     (mid)
    );

    c3ca_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (b_adv),
        .top     (top),
        .mid     (mid),
        .pix     (b_pix_reg),
        .k_top   (k_top_reg),
        .k_mid   (k_mid_reg),
        .k_bot   (k_bot_reg),
        .prod    (prod)
    );

    c3ca_reduce u_reduce (
        .aclk      (aclk),
        .row_en    (c_adv),
        .out_en    (d_adv),
        .prod      (prod),
        .tag       (c_tag_reg),
        .out_pixel (out_pixel),
        .out_last  (out_last)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_pixel;
    assign m_tlast  = out_last;

    `C3CA_ASSERT(a_no_same_col_rw, aclk, aresetn, (s_acc && b_valid_reg) |-> (col_reg != b_col_reg), "line store read and write-back hit the same column")
    `C3CA_ASSERT(a_frame_wrap, aclk, aresetn, (s_acc && eof) |=> (col_reg == '0 && row_reg == '0), "frame end did not return the raster position to origin")
    `C3CA_ASSERT(a_accept_needs_room, aclk, aresetn, (s_acc && b_valid_reg) |-> b_adv, "word taken while the read stage was held")
    `C3CA_ASSERT_RST(a_reset_empty, aclk, aresetn, (!m_tvalid && !b_valid_reg && !c_valid_reg && !d_valid_reg), "pipeline not empty after reset")

endmodule

[sv/c3ca_line_store.sv]
module c3ca_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  c3ca_pkg::pix_t      wr_pix,
    output c3ca_pkg::pix_t      top,
    output c3ca_pkg::pix_t      mid
);
    import c3ca_pkg::*;

    pix_t upper_mem [DEPTH];
    pix_t lower_mem [DEPTH];
    pix_t top_reg;
    pix_t mid_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            top_reg <= upper_mem[rd_addr];
            mid_reg <= lower_mem[rd_addr];
        end
    end

    // Roll rows: the middle line moves up, the new pixel becomes the middle line.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr] <= mid_reg;
            lower_mem[wr_addr] <= wr_pix;
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

[sv/c3ca_window.sv]
module c3ca_window (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  c3ca_pkg::pix_t          top,
    input  c3ca_pkg::pix_t          mid,
    input  c3ca_pkg::pix_t          pix,
    input  c3ca_pkg::kern_t         k_top,
    input  c3ca_pkg::kern_t         k_mid,
    input  c3ca_pkg::kern_t         k_bot,
    output c3ca_pkg::prod_t [8:0]   prod
);
    import c3ca_pkg::*;

    pix_t            win_reg [6];
    prod_t [8:0]     prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (en) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= coef_mul(kbyte(k_top, 0), win_reg[0]);
            prod_reg[1] <= coef_mul(kbyte(k_top, 1), win_reg[1]);
            prod_reg[2] <= coef_mul(kbyte(k_top, 2), top);
            prod_reg[3] <= coef_mul(kbyte(k_mid, 0), win_reg[2]);
            prod_reg[4] <= coef_mul(kbyte(k_mid, 1), win_reg[3]);
            prod_reg[5] <= coef_mul(kbyte(k_mid, 2), mid);
            prod_reg[6] <= coef_mul(kbyte(k_bot, 0), win_reg[4]);
            prod_reg[7] <= coef_mul(kbyte(k_bot, 1), win_reg[5]);
            prod_reg[8] <= coef_mul(kbyte(k_bot, 2), pix);
        end
    end

    assign prod = prod_reg;

endmodule

[sv/c3ca_reduce.sv]
module c3ca_reduce (
    input  logic                    aclk,
    input  logic                    row_en,
    input  logic                    out_en,
    input  c3ca_pkg::prod_t [8:0]   prod,
    input  c3ca_pkg::tag_t          tag,
    output c3ca_pkg::pix_t          out_pixel,
    output logic                    out_last
);
    import c3ca_pkg::*;

    rsum_t   rs_reg [3];
    tag_t    tag_reg;
    pix_t    out_pix_reg;
    logic    out_last_reg;

    tot_t            total;
    pix_t            conv;
    logic [PIX_W:0]  sum_acc;
    pix_t            sat;

    always_ff @(posedge aclk) begin
        if (row_en) begin
            for (int r = 0; r < 3; r++) begin
                rs_reg[r] <= RSUM_W'($signed(prod[3*r]))
                           + RSUM_W'($signed(prod[3*r+1]))
                           + RSUM_W'($signed(prod[3*r+2]));
            end
            tag_reg <= tag;
        end
    end

    always_comb begin
        total = TOT_W'(rs_reg[0]) + TOT_W'(rs_reg[1]) + TOT_W'(rs_reg[2]);
        // Clamp to 0..255 and drop the fraction.
        if (total[TOT_W-1] || total == '0) begin
            conv = '0;
        end else if (total >= CONV_SAT) begin
            conv = pix_t'(PIX_MAX);
        end else begin
            conv = total[FRAC_W +: PIX_W];
        end
        sum_acc = {1'b0, conv} + {1'b0, tag_reg.acc};
        sat     = sum_acc[PIX_W] ? pix_t'(PIX_MAX) : sum_acc[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_pix_reg  <= sat;
            out_last_reg <= tag_reg.last;
        end
    end

    assign out_pixel = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule
